@@ sv/i2cbl_pkg.sv @@
// ============================================================================
// i2cbl_pkg: shared types and constants for the I2C bootloader frame parser
// Holds the phase and event encodings, the config reset values and the
// state and config structs passed between the top level and the step logic.
// ============================================================================
package i2cbl_pkg;

    localparam int unsigned ADDR_W  = 7;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned WORD_W  = 16;
    localparam int unsigned CFG_IDX_W = 2;

    // Config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER     = 2'd2;

    // Config reset values
    localparam logic [ADDR_W-1:0] RST_DEVICE_ADDRESS = 7'h70;
    localparam logic [BYTE_W-1:0] RST_START_MARKER   = 8'h01;
    localparam logic [BYTE_W-1:0] RST_END_MARKER     = 8'h17;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_SOP    = 4'd1,
        PH_CMD    = 4'd2,
        PH_LEN_LO = 4'd3,
        PH_LEN_HI = 4'd4,
        PH_DATA   = 4'd5,
        PH_SUM_LO = 4'd6,
        PH_SUM_HI = 4'd7,
        PH_EOP    = 4'd8
    } t_phase;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_ADDR    = 3'd1,
        EV_SOP_ERR = 3'd2,
        EV_CMD     = 3'd3,
        EV_DATA    = 3'd4,
        EV_OK      = 3'd5,
        EV_BAD_EOP = 3'd6,
        EV_FIELD   = 3'd7
    } t_event;

    typedef struct packed {
        t_phase              phase;
        logic                rw;
        logic [BYTE_W-1:0]   cmd;
        logic [WORD_W-1:0]   length;
        logic [WORD_W-1:0]   seen;
        logic [WORD_W-1:0]   checksum;
    } t_frame_state;

    typedef struct packed {
        logic [ADDR_W-1:0] device_address;
        logic [BYTE_W-1:0] start_marker;
        logic [BYTE_W-1:0] end_marker;
    } t_cfg;

    typedef struct packed {
        t_event            kind;
        logic [WORD_W-1:0] index;
        logic              last;
    } t_step_result;

endpackage

@@ sv/i2cbl_step.sv @@
// ============================================================================
// i2cbl_step: one parser step
// Combinational next state and event for one bus byte, from the current
// frame state and the config registers.
// ============================================================================
module i2cbl_step (
    input  i2cbl_pkg::t_frame_state           i_cur,
    input  i2cbl_pkg::t_cfg                   i_cfg,
    input  logic [i2cbl_pkg::BYTE_W-1:0]      i_bus_byte,
    input  logic                              i_after_start,
    output i2cbl_pkg::t_frame_state           o_nxt,
    output i2cbl_pkg::t_step_result           o_res
);

    logic [i2cbl_pkg::WORD_W-1:0] seen_inc;
    logic [i2cbl_pkg::WORD_W-1:0] len_full;

    assign seen_inc = i_cur.seen + 16'd1;
    assign len_full = {i_bus_byte, i_cur.length[i2cbl_pkg::BYTE_W-1:0]};

    always_comb begin
        o_nxt       = i_cur;
        o_res.kind  = i2cbl_pkg::EV_NONE;
        o_res.index = '0;
        o_res.last  = 1'b0;
        case (i_cur.phase)
            i2cbl_pkg::PH_SOP: begin
                if (i_bus_byte != i_cfg.start_marker) begin
                    o_res.kind  = i2cbl_pkg::EV_SOP_ERR;
                    o_nxt.phase = i2cbl_pkg::PH_IDLE;
                end else begin
                    o_nxt.phase = i2cbl_pkg::PH_CMD;
                end
            end
            i2cbl_pkg::PH_CMD: begin
                o_nxt.cmd   = i_bus_byte;
                o_res.kind  = i2cbl_pkg::EV_CMD;
                o_nxt.phase = i2cbl_pkg::PH_LEN_LO;
            end
            i2cbl_pkg::PH_LEN_LO: begin
                o_nxt.length = {8'd0, i_bus_byte};
                o_res.kind   = i2cbl_pkg::EV_FIELD;
                o_nxt.phase  = i2cbl_pkg::PH_LEN_HI;
            end
            i2cbl_pkg::PH_LEN_HI: begin
                o_nxt.length = len_full;
                o_nxt.seen   = '0;
                o_res.kind   = i2cbl_pkg::EV_FIELD;
                // zero length goes straight to the checksum
                o_nxt.phase  = (len_full == '0) ? i2cbl_pkg::PH_SUM_LO
                                                : i2cbl_pkg::PH_DATA;
            end
            i2cbl_pkg::PH_DATA: begin
                o_res.index = i_cur.seen;
                o_nxt.seen  = seen_inc;
                o_res.kind  = i2cbl_pkg::EV_DATA;
                if (seen_inc == i_cur.length) begin
                    o_res.last  = 1'b1;
                    o_nxt.phase = i2cbl_pkg::PH_SUM_LO;
                end
            end
            i2cbl_pkg::PH_SUM_LO: begin
                o_nxt.checksum = {8'd0, i_bus_byte};
                o_res.kind     = i2cbl_pkg::EV_FIELD;
                o_nxt.phase    = i2cbl_pkg::PH_SUM_HI;
            end
            i2cbl_pkg::PH_SUM_HI: begin
                o_nxt.checksum = {i_bus_byte, i_cur.checksum[i2cbl_pkg::BYTE_W-1:0]};
                o_res.kind     = i2cbl_pkg::EV_FIELD;
                o_nxt.phase    = i2cbl_pkg::PH_EOP;
            end
            i2cbl_pkg::PH_EOP: begin
                o_res.kind  = (i_bus_byte == i_cfg.end_marker) ? i2cbl_pkg::EV_OK
                                                               : i2cbl_pkg::EV_BAD_EOP;
                o_nxt.phase = i2cbl_pkg::PH_IDLE;
            end
            default: begin
                // idle: address match on a byte right after a start condition
                o_nxt.phase = i2cbl_pkg::PH_IDLE;
                if (i_after_start &&
                    (i_bus_byte[i2cbl_pkg::BYTE_W-1:1] == i_cfg.device_address)) begin
                    o_nxt.rw    = i_bus_byte[0];
                    o_res.kind  = i2cbl_pkg::EV_ADDR;
                    o_nxt.phase = i2cbl_pkg::PH_SOP;
                end
            end
        endcase
    end

endmodule

@@ sv/i2c_bootloader_frame_parser.sv @@
// ============================================================================
// i2c_bootloader_frame_parser: bootloader frame parser on decoded I2C bytes
// Matches the device address, checks the start marker, collects command,
// length, payload, checksum and end marker, and reports one event per byte.
// ============================================================================
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+------------------------------
//  in       | to block  | i_in_valid / o_in_stall  | i_bus_byte, i_after_start
//  out      | from blk  | o_out_valid / i_out_stall| o_event_kind .. o_frame_checksum
//  cfg      | to block  | i_cfg_we                 | i_cfg_index, i_cfg_data
//
//  Each accepted request is handled in the cycle it is taken; its event sits
//  in the output register the next cycle. One request per cycle unless the sink
//  stalls, set by the single output register (taken or emptying lets the next in).
//  o_in_stall is high only while a result waits and the sink stalls.
//  Reset (i_rst_n low, synchronous) clears the frame state, empties the
//  output register and loads the config reset values.
//
module i2c_bootloader_frame_parser (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // config write port
    input  logic                                 i_cfg_we,
    input  logic [i2cbl_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [i2cbl_pkg::BYTE_W-1:0]         i_cfg_data,
    // input request channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [i2cbl_pkg::BYTE_W-1:0]         i_bus_byte,
    input  logic                                 i_after_start,
    // result channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [2:0]                           o_event_kind,
    output logic [i2cbl_pkg::BYTE_W-1:0]         o_byte_value,
    output logic                                 o_direction_bit,
    output logic [i2cbl_pkg::BYTE_W-1:0]         o_command_code,
    output logic [i2cbl_pkg::WORD_W-1:0]         o_payload_length,
    output logic [i2cbl_pkg::WORD_W-1:0]         o_data_index,
    output logic                                 o_last_data,
    output logic [i2cbl_pkg::WORD_W-1:0]         o_frame_checksum
);

    // config registers
    i2cbl_pkg::t_cfg         r_cfg;
    // frame state, updated once per accepted request
    i2cbl_pkg::t_frame_state r_state;
    i2cbl_pkg::t_frame_state n_state;
    i2cbl_pkg::t_step_result step_res;

    // output register
    logic                              r_out_valid;
    i2cbl_pkg::t_event                 r_event;
    logic [i2cbl_pkg::BYTE_W-1:0]      r_byte;
    logic [i2cbl_pkg::WORD_W-1:0]      r_index;
    logic                              r_last;

    logic in_take;
    logic out_take;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_take    = i_in_valid & ~o_in_stall;
    assign out_take   = r_out_valid & ~i_out_stall;

    i2cbl_step u_step (
        .i_cur         (r_state),
        .i_cfg         (r_cfg),
        .i_bus_byte    (i_bus_byte),
        .i_after_start (i_after_start),
        .o_nxt         (n_state),
        .o_res         (step_res)
    );

    // config writes; an unused index is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.device_address <= i2cbl_pkg::RST_DEVICE_ADDRESS;
            r_cfg.start_marker   <= i2cbl_pkg::RST_START_MARKER;
            r_cfg.end_marker     <= i2cbl_pkg::RST_END_MARKER;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                i2cbl_pkg::CFG_DEVICE_ADDRESS: begin
                    r_cfg.device_address <= i_cfg_data[i2cbl_pkg::ADDR_W-1:0];
                end
                i2cbl_pkg::CFG_START_MARKER: begin
                    r_cfg.start_marker <= i_cfg_data;
                end
                i2cbl_pkg::CFG_END_MARKER: begin
                    r_cfg.end_marker <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // frame state; the latched fields are visible on the outputs, so they reset too
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase    <= i2cbl_pkg::PH_IDLE;
            r_state.rw       <= 1'b0;
            r_state.cmd      <= '0;
            r_state.length   <= '0;
            r_state.seen     <= '0;
            r_state.checksum <= '0;
        end else if (in_take) begin
            r_state <= n_state;
        end
    end

    // output valid: filled on a take, emptied when the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_take) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    // per-event payload; the latched fields come straight from r_state,
    // which holds the after-step values while the result waits
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_event <= step_res.kind;
            r_byte  <= i_bus_byte;
            r_index <= step_res.index;
            r_last  <= step_res.last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_event_kind     = r_event;
    assign o_byte_value     = r_byte;
    assign o_direction_bit  = r_state.rw;
    assign o_command_code   = r_state.cmd;
    assign o_payload_length = r_state.length;
    assign o_data_index     = r_index;
    assign o_last_data      = r_last;
    assign o_frame_checksum = r_state.checksum;

endmodule

@@ sv/i2cbl_checker.sv @@
// ============================================================================
// i2cbl_checker: port-level checks for the I2C bootloader frame parser
// Watches the top-level ports only; bound to the top level below.
// ============================================================================
module i2cbl_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic [2:0]                        o_event_kind,
    input logic [i2cbl_pkg::BYTE_W-1:0]      o_byte_value,
    input logic [i2cbl_pkg::WORD_W-1:0]      o_data_index,
    input logic                              o_last_data
);

    // an accepted request always shows a result the next cycle
    a_take_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("accepted request produced no result");

    // the input side only stalls behind a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a waiting result");

    // a stalled result holds its event and byte
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_event_kind) && $stable(o_byte_value)))
        else $error("stalled result changed");

    // index and last flag are only meaningful on data events
    a_data_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_event_kind != i2cbl_pkg::EV_DATA)) |->
            ((o_data_index == '0) && !o_last_data))
        else $error("data index or last flag on a non-data event");

    // output register empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind i2c_bootloader_frame_parser i2cbl_checker u_i2cbl_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_event_kind (o_event_kind),
    .o_byte_value (o_byte_value),
    .o_data_index (o_data_index),
    .o_last_data  (o_last_data)
);

@@ dv/i2cbl_event_checker.sv @@
// ============================================================================
// i2cbl_event_checker: result checker for the I2C bootloader frame parser
// Watches the config port and both request channels, predicts one event per
// accepted request and compares every accepted result against it in order.
// ============================================================================
`timescale 1ns / 1ps

module i2cbl_event_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [i2cbl_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [i2cbl_pkg::BYTE_W-1:0]        i_cfg_data,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  logic [i2cbl_pkg::BYTE_W-1:0]        i_bus_byte,
    input  logic                                i_after_start,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic [2:0]                          i_event_kind,
    input  logic [i2cbl_pkg::BYTE_W-1:0]        i_byte_value,
    input  logic                                i_direction_bit,
    input  logic [i2cbl_pkg::BYTE_W-1:0]        i_command_code,
    input  logic [i2cbl_pkg::WORD_W-1:0]        i_payload_length,
    input  logic [i2cbl_pkg::WORD_W-1:0]        i_data_index,
    input  logic                                i_last_data,
    input  logic [i2cbl_pkg::WORD_W-1:0]        i_frame_checksum,
    output int                                  o_fail_count,
    output int                                  o_pending,
    output int                                  o_events_seen,
    output int                                  o_frames_ok
);

    typedef struct packed {
        i2cbl_pkg::t_event                kind;
        logic [i2cbl_pkg::BYTE_W-1:0]     value;
        logic                             dir;
        logic [i2cbl_pkg::BYTE_W-1:0]     cmd;
        logic [i2cbl_pkg::WORD_W-1:0]     len;
        logic [i2cbl_pkg::WORD_W-1:0]     idx;
        logic                             last;
        logic [i2cbl_pkg::WORD_W-1:0]     sum;
    } t_frame_event;

    // predicted parser state and config copy
    i2cbl_pkg::t_phase                parse_phase;
    logic                             rw_q;
    logic [i2cbl_pkg::BYTE_W-1:0]     cmd_q;
    logic [i2cbl_pkg::WORD_W-1:0]     len_q;
    logic [i2cbl_pkg::WORD_W-1:0]     seen_q;
    logic [i2cbl_pkg::WORD_W-1:0]     sum_q;
    logic [i2cbl_pkg::ADDR_W-1:0]     addr_cfg;
    logic [i2cbl_pkg::BYTE_W-1:0]     sop_cfg;
    logic [i2cbl_pkg::BYTE_W-1:0]     eop_cfg;

    t_frame_event expected_events[$];
    t_frame_event want;

    initial begin
        o_fail_count  = 0;
        o_pending     = 0;
        o_events_seen = 0;
        o_frames_ok   = 0;
    end

    function automatic t_frame_event parse_byte(input logic [7:0] b, input logic s);
        t_frame_event e;
        e.kind = i2cbl_pkg::EV_NONE;
        e.idx  = '0;
        e.last = 1'b0;
        case (parse_phase)
            i2cbl_pkg::PH_SOP: begin
                if (b != sop_cfg) begin
                    e.kind      = i2cbl_pkg::EV_SOP_ERR;
                    parse_phase = i2cbl_pkg::PH_IDLE;
                end else begin
                    parse_phase = i2cbl_pkg::PH_CMD;
                end
            end
            i2cbl_pkg::PH_CMD: begin
                cmd_q       = b;
                e.kind      = i2cbl_pkg::EV_CMD;
                parse_phase = i2cbl_pkg::PH_LEN_LO;
            end
            i2cbl_pkg::PH_LEN_LO: begin
                len_q       = {8'h00, b};
                e.kind      = i2cbl_pkg::EV_FIELD;
                parse_phase = i2cbl_pkg::PH_LEN_HI;
            end
            i2cbl_pkg::PH_LEN_HI: begin
                len_q       = {b, len_q[7:0]};
                seen_q      = '0;
                e.kind      = i2cbl_pkg::EV_FIELD;
                parse_phase = (len_q == '0) ? i2cbl_pkg::PH_SUM_LO : i2cbl_pkg::PH_DATA;
            end
            i2cbl_pkg::PH_DATA: begin
                e.idx  = seen_q;
                seen_q = seen_q + 16'd1;
                e.kind = i2cbl_pkg::EV_DATA;
                if (seen_q == len_q) begin
                    e.last      = 1'b1;
                    parse_phase = i2cbl_pkg::PH_SUM_LO;
                end
            end
            i2cbl_pkg::PH_SUM_LO: begin
                sum_q       = {8'h00, b};
                e.kind      = i2cbl_pkg::EV_FIELD;
                parse_phase = i2cbl_pkg::PH_SUM_HI;
            end
            i2cbl_pkg::PH_SUM_HI: begin
                sum_q       = {b, sum_q[7:0]};
                e.kind      = i2cbl_pkg::EV_FIELD;
                parse_phase = i2cbl_pkg::PH_EOP;
            end
            i2cbl_pkg::PH_EOP: begin
                e.kind      = (b == eop_cfg) ? i2cbl_pkg::EV_OK : i2cbl_pkg::EV_BAD_EOP;
                parse_phase = i2cbl_pkg::PH_IDLE;
            end
            default: begin
                parse_phase = i2cbl_pkg::PH_IDLE;
                if (s && b[7:1] == addr_cfg) begin
                    rw_q        = b[0];
                    e.kind      = i2cbl_pkg::EV_ADDR;
                    parse_phase = i2cbl_pkg::PH_SOP;
                end
            end
        endcase
        e.value = b;
        e.dir   = rw_q;
        e.cmd   = cmd_q;
        e.len   = len_q;
        e.sum   = sum_q;
        return e;
    endfunction

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned got_v);
        if (exp_v != got_v) begin
            if (o_fail_count < 10)
                $display("[%0t] %s mismatch: expected 0x%0h, got 0x%0h",
                         $time, name, exp_v, got_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            parse_phase = i2cbl_pkg::PH_IDLE;
            rw_q        = 1'b0;
            cmd_q       = '0;
            len_q       = '0;
            seen_q      = '0;
            sum_q       = '0;
            addr_cfg    = i2cbl_pkg::RST_DEVICE_ADDRESS;
            sop_cfg     = i2cbl_pkg::RST_START_MARKER;
            eop_cfg     = i2cbl_pkg::RST_END_MARKER;
            expected_events.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    i2cbl_pkg::CFG_DEVICE_ADDRESS:
                        addr_cfg = i_cfg_data[i2cbl_pkg::ADDR_W-1:0];
                    i2cbl_pkg::CFG_START_MARKER:   sop_cfg  = i_cfg_data;
                    i2cbl_pkg::CFG_END_MARKER:     eop_cfg  = i_cfg_data;
                    default: ;
                endcase
            end
            // results first, so a result never matches the request of this edge
            if (i_out_valid && !i_out_stall) begin
                o_events_seen++;
                if (expected_events.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("[%0t] result with nothing expected: kind %0d byte 0x%0h",
                                 $time, i_event_kind, i_byte_value);
                    o_fail_count++;
                end else begin
                    want = expected_events.pop_front();
                    check_field("event_kind",     want.kind,  i_event_kind);
                    check_field("byte_value",     want.value, i_byte_value);
                    check_field("direction_bit",  want.dir,   i_direction_bit);
                    check_field("command_code",   want.cmd,   i_command_code);
                    check_field("payload_length", want.len,   i_payload_length);
                    check_field("data_index",     want.idx,   i_data_index);
                    check_field("last_data",      want.last,  i_last_data);
                    check_field("frame_checksum", want.sum,   i_frame_checksum);
                    if (want.kind == i2cbl_pkg::EV_OK)
                        o_frames_ok++;
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_events.push_back(parse_byte(i_bus_byte, i_after_start));
        end
        o_pending = expected_events.size();
    end

endmodule

@@ dv/tb_top.sv @@
// ============================================================================
// tb_top: testbench top for the I2C bootloader frame parser
// Drives byte requests (directed frames, then random frames and noise) under
// random source gaps and sink stalls across several register settings; the
// checker predicts and compares, this module issues the verdict.
// ============================================================================
`timescale 1ns / 1ps

module tb_top;

    // index 3 is not a register; writes to it must be ignored
    localparam logic [i2cbl_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int QUIET_LIMIT  = 2000;   // cycles without any handshake
    localparam int PHASE_BYTES  = 135;    // frame bytes per register setting
    localparam int N_DIRECTED   = 23;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n;
    logic                                 i_cfg_we;
    logic [i2cbl_pkg::CFG_IDX_W-1:0]      i_cfg_index;
    logic [i2cbl_pkg::BYTE_W-1:0]         i_cfg_data;
    logic                                 i_in_valid;
    logic                                 o_in_stall;
    logic [i2cbl_pkg::BYTE_W-1:0]         i_bus_byte;
    logic                                 i_after_start;
    logic                                 o_out_valid;
    logic                                 i_out_stall;
    logic [2:0]                           o_event_kind;
    logic [i2cbl_pkg::BYTE_W-1:0]         o_byte_value;
    logic                                 o_direction_bit;
    logic [i2cbl_pkg::BYTE_W-1:0]         o_command_code;
    logic [i2cbl_pkg::WORD_W-1:0]         o_payload_length;
    logic [i2cbl_pkg::WORD_W-1:0]         o_data_index;
    logic                                 o_last_data;
    logic [i2cbl_pkg::WORD_W-1:0]         o_frame_checksum;

    int fail_count;
    int pending_events;
    int events_seen;
    int frames_ok;

    // stimulus bookkeeping
    int                               n_requests = 0;
    int                               n_noise    = 0;
    int                               n_settings = 1;  // reset values count as the first
    int                               quiet_cycles = 0;
    logic                             calm = 1'b0;     // no gaps or stalls while set
    logic [i2cbl_pkg::ADDR_W-1:0]     cur_addr = i2cbl_pkg::RST_DEVICE_ADDRESS;
    logic [i2cbl_pkg::BYTE_W-1:0]     cur_sop  = i2cbl_pkg::RST_START_MARKER;
    logic [i2cbl_pkg::BYTE_W-1:0]     cur_eop  = i2cbl_pkg::RST_END_MARKER;

    always #2 i_clk = ~i_clk;

    i2c_bootloader_frame_parser u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_bus_byte       (i_bus_byte),
        .i_after_start    (i_after_start),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_event_kind     (o_event_kind),
        .o_byte_value     (o_byte_value),
        .o_direction_bit  (o_direction_bit),
        .o_command_code   (o_command_code),
        .o_payload_length (o_payload_length),
        .o_data_index     (o_data_index),
        .o_last_data      (o_last_data),
        .o_frame_checksum (o_frame_checksum)
    );

    i2cbl_event_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_bus_byte       (i_bus_byte),
        .i_after_start    (i_after_start),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_event_kind     (o_event_kind),
        .i_byte_value     (o_byte_value),
        .i_direction_bit  (o_direction_bit),
        .i_command_code   (o_command_code),
        .i_payload_length (o_payload_length),
        .i_data_index     (o_data_index),
        .i_last_data      (o_last_data),
        .i_frame_checksum (o_frame_checksum),
        .o_fail_count     (fail_count),
        .o_pending        (pending_events),
        .o_events_seen    (events_seen),
        .o_frames_ok      (frames_ok)
    );

    // ------------------------------------------------------------------------
    // Watchdog: any cycle without a request or result handshake counts.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                         quiet_cycles, pending_events);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sink: stall or ready runs, each picked anew; stall runs mostly short, a few long.
    // ------------------------------------------------------------------------
    initial begin : sink_side
        int   run;
        logic level;
        run   = 0;
        level = 1'b0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (run == 0) begin
                level = !calm && ($urandom_range(0, 99) < 35);
                if (level)
                    run = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                     : $urandom_range(10, 40);
                else
                    run = $urandom_range(1, 12);
            end
            i_out_stall <= level;
            run--;
        end
    end

    // Source gap before a request: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // start flag on a mid-frame byte, which the parser must ignore
    function automatic logic mid_flag();
        return ($urandom_range(0, 7) == 0);
    endfunction

    // ------------------------------------------------------------------------
    // One byte request. Called right after a rising edge, returns right after
    // the edge that took it. Valid stays high into the next request when no
    // gap is chosen, so valid gets a single assignment per step. Stall is
    // sampled at the falling edge, where it is settled for the next rise.
    // ------------------------------------------------------------------------
    task automatic put_byte(input logic [7:0] b, input logic s);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_bus_byte    <= b;
        i_after_start <= s;
        do @(negedge i_clk); while (o_in_stall);
        @(posedge i_clk);
        n_requests++;
    endtask

    // Stop sending and hold until every predicted event has come back.
    task automatic drain_events();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending_events != 0);
        @(posedge i_clk);
    endtask

    // Writes all three registers plus the unused index; only while drained.
    // Bit 7 of the address write is random: the register keeps 7 bits.
    task automatic load_settings(input logic [6:0] addr, input logic [7:0] sop,
                                 input logic [7:0] eop);
        logic junk_bit;
        junk_bit    = 1'($urandom_range(0, 1));
        i_cfg_we    <= 1'b1;
        i_cfg_index <= i2cbl_pkg::CFG_DEVICE_ADDRESS;
        i_cfg_data  <= {junk_bit, addr};
        @(posedge i_clk);
        i_cfg_index <= i2cbl_pkg::CFG_START_MARKER;
        i_cfg_data  <= sop;
        @(posedge i_clk);
        i_cfg_index <= i2cbl_pkg::CFG_END_MARKER;
        i_cfg_data  <= eop;
        @(posedge i_clk);
        i_cfg_index <= CFG_UNUSED;
        i_cfg_data  <= 8'($urandom_range(0, 255));
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_addr = addr;
        cur_sop  = sop;
        cur_eop  = eop;
        n_settings++;
    endtask

    // Full frame for the current address; optionally breaks the end marker, or
    // breaks the start marker and stops there. Contents are random.
    task automatic send_frame(input logic [15:0] len, input bit bad_sop, input bit bad_eop);
        int unsigned k;
        logic        rw;
        rw = 1'($urandom_range(0, 1));
        put_byte({cur_addr, rw}, 1'b1);
        if (bad_sop) begin
            put_byte(cur_sop ^ 8'($urandom_range(1, 255)), mid_flag());
            return;
        end
        put_byte(cur_sop, mid_flag());
        put_byte(8'($urandom_range(0, 255)), mid_flag());       // command
        put_byte(len[7:0], mid_flag());
        put_byte(len[15:8], mid_flag());
        for (k = 0; k < len; k++)
            put_byte(8'($urandom_range(0, 255)), mid_flag());
        put_byte(8'($urandom_range(0, 255)), mid_flag());       // checksum lo
        put_byte(8'($urandom_range(0, 255)), mid_flag());       // checksum hi
        put_byte(bad_eop ? cur_eop ^ 8'($urandom_range(1, 255)) : cur_eop, mid_flag());
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        // directed bytes at reset settings (address 0x70, markers 0x01/0x17),
        // each entry is {after_start, bus_byte}
        logic [8:0]  directed [N_DIRECTED] = '{
            9'h0E0,                     // address without start flag: ignored
            9'h1E2,                     // start flag, other address
            9'h1FF,                     // start flag, all ones
            9'h1E1, 9'h000,             // hit with read bit, then bad start marker
            9'h1E0, 9'h101,             // hit with write bit, marker with start flag set
            9'h0FF, 9'h000, 9'h100,     // command, zero length: straight to checksum
            9'h0FF, 9'h000, 9'h017,     // checksum, good end marker
            9'h1E1, 9'h001, 9'h000,     // new frame keeps old length/checksum until set
            9'h002, 9'h000,             // length 2
            9'h180, 9'h07F,             // data, start flag ignored, last byte
            9'h000, 9'h0FF, 9'h0E0      // checksum, bad end marker
        };
        int          i;
        int          p;
        int          frame_no;
        int          phase_base;
        int          r;
        logic [15:0] len;

        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= i2cbl_pkg::CFG_DEVICE_ADDRESS;
        i_cfg_data    <= '0;
        i_in_valid    <= 1'b0;
        i_bus_byte    <= '0;
        i_after_start <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < N_DIRECTED; i++)
            put_byte(directed[i][7:0], directed[i][8]);

        frame_no = 0;
        for (p = 0; p < 4; p++) begin
            // settings change only with nothing in flight
            if (p > 0) begin
                drain_events();
                case (p)
                    1:       load_settings(7'h00, 8'h00, 8'h00);
                    2:       load_settings(7'h7F, 8'hFF, 8'hFF);
                    default: load_settings(7'($urandom_range(0, 127)),
                                           8'($urandom_range(0, 255)),
                                           8'($urandom_range(0, 255)));
                endcase
            end
            // one long payload so the index and length cross the low byte
            if (p == 2)
                send_frame(16'h0100 + 16'($urandom_range(0, 4)), 1'b0, 1'b0);

            phase_base = n_requests - n_noise;
            while (n_requests - n_noise - phase_base < PHASE_BYTES) begin
                if (frame_no % 8 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                frame_no++;

                // idle noise: random bytes and flags between frames
                if ($urandom_range(0, 3) == 0) begin
                    repeat ($urandom_range(1, 3)) begin
                        put_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                        n_noise++;
                    end
                end

                // occasionally let every result come home before going on
                if ($urandom_range(0, 29) == 0)
                    drain_events();

                r = $urandom_range(0, 99);
                if (r < 10)
                    len = '0;
                else if (r < 85)
                    len = 16'($urandom_range(1, 6));
                else if (r < 97)
                    len = 16'($urandom_range(7, 40));
                else
                    len = 16'($urandom_range(41, 80));

                r = $urandom_range(0, 99);
                send_frame(len, r < 8, r >= 8 && r < 16);
            end
        end

        calm = 1'b0;
        drain_events();
        repeat (4) @(posedge i_clk);

        $display("Summary: %0d byte requests (%0d idle noise) over %0d register settings,",
                 n_requests, n_noise, n_settings);
        $display("         %0d events checked, %0d frames closed with a good end marker",
                 events_seen, frames_ok);
        if (fail_count == 0 && pending_events == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d events never seen", fail_count, pending_events);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/i2cbl_pkg.sv
sv/i2cbl_step.sv
sv/i2c_bootloader_frame_parser.sv
sv/i2cbl_checker.sv
dv/i2cbl_event_checker.sv
dv/tb_top.sv
